>>> src/ppb_pkg.sv
// Shared types and constants for the perceptron branch predictor.
// Used by ppb_lane, ppb_merge and the top level; no dependencies.
package ppb_pkg;

  localparam int HISTORY_LENGTH_DEF = 16;
  localparam int INDEX_BITS_DEF     = 8;

  localparam int WEIGHT_W = 8;   // stored weight, signed
  localparam int TERM_W   = 9;   // +/- weight, signed
  localparam int THR_W    = 12;  // confidence threshold
  localparam int LIM_W    = 7;   // weight limit
  localparam int DOT_W    = 13;  // dot_sum / fetch_sum field
  localparam int ROW_W    = 8;   // row_index field
  localparam int CFG_W    = 12;  // widest config register

  localparam int DOT_MAX = 4095;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(45);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(127);

  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_LIMIT     = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LANE,
    ST_SUM
  } st_t;

  typedef struct packed {
    logic capture;  // read data valid: latch term / new weight
    logic wr_en;    // write the row
    logic clear;    // write zero instead of the new weight
  } lane_ctrl_t;

endpackage

>>> src/ppb_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ppb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/ppb_lane.sv
// One weight lane: a column of weights, one per row, plus the per-weight
// term and saturating update. Depends on ppb_pkg and ppb_ram.
module ppb_lane #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  ppb_pkg::lane_ctrl_t                 ctrl,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic                                hist_bit,
  input  logic                                taken,
  input  logic [ppb_pkg::LIM_W-1:0]           limit,
  output logic signed [ppb_pkg::TERM_W-1:0]   term,
  output logic                                changed
);

  logic [ppb_pkg::WEIGHT_W-1:0]        rdata;
  logic [ppb_pkg::WEIGHT_W-1:0]        nw;
  logic [ppb_pkg::WEIGHT_W-1:0]        nw_next;
  logic [ppb_pkg::WEIGHT_W-1:0]        wdata;
  logic signed [ppb_pkg::TERM_W-1:0]   w_x;
  logic signed [ppb_pkg::TERM_W-1:0]   sum_v;
  logic signed [ppb_pkg::TERM_W-1:0]   lim_x;
  logic signed [ppb_pkg::TERM_W-1:0]   delta;

  ppb_ram #(
    .WIDTH(ppb_pkg::WEIGHT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.wr_en),
    .waddr(wr_addr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign wdata = ctrl.clear ? '0 : nw;

  always_comb begin
    w_x   = ppb_pkg::TERM_W'($signed(rdata));
    lim_x = $signed({{(ppb_pkg::TERM_W-ppb_pkg::LIM_W){1'b0}}, limit});
    // step toward the outcome: +1 when outcome agrees with the input bit
    delta = (taken == hist_bit) ? ppb_pkg::TERM_W'(1) : -ppb_pkg::TERM_W'(1);
    sum_v = w_x + delta;
    if (sum_v > lim_x) begin
      nw_next = lim_x[ppb_pkg::WEIGHT_W-1:0];
    end else if (sum_v < -lim_x) begin
      nw_next = ppb_pkg::WEIGHT_W'(-lim_x);
    end else begin
      nw_next = sum_v[ppb_pkg::WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      term    <= hist_bit ? w_x : -w_x;
      nw      <= nw_next;
      changed <= (nw_next != rdata);
    end
  end

endmodule

>>> src/ppb_merge.sv
// Adder tree that merges the lane terms into the dot product: groups of
// eight lanes are summed and registered, then the group sums are added.
// Depends on ppb_pkg.
module ppb_merge #(
  parameter int LANES = 17,
  parameter int SUM_W = 13
) (
  input  logic                                   clk,
  input  logic                                   load,
  input  logic [LANES-1:0][ppb_pkg::TERM_W-1:0]  terms,
  output logic signed [SUM_W-1:0]                total
);

  localparam int GROUPS = (LANES + 7) / 8;

  logic signed [SUM_W-1:0] grp_next [GROUPS];
  logic signed [SUM_W-1:0] grp      [GROUPS];

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_next[g] = '0;
      for (int i = 0; i < 8; i++) begin
        if (g * 8 + i < LANES) begin
          grp_next[g] = grp_next[g] + SUM_W'($signed(terms[g*8+i]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < GROUPS; g++) begin
        grp[g] <= grp_next[g];
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + grp[g];
    end
  end

endmodule

>>> src/perceptron_branch_predictor_unit.sv
// Perceptron branch predictor top level: control FSM, config registers,
// lanes and merge tree. Depends on ppb_pkg, ppb_lane, ppb_merge.
// The row is read at the accepting edge, then the lane, group-sum and final
// sum/compare stages follow in order before done rises. The FSM walks its stages
// before taking the next item. Receiver cannot stall.
// Reset: synchronous; busy while the 2**INDEX_BITS rows (256 default) clear.
module perceptron_branch_predictor_unit #(
  parameter int HISTORY_LENGTH = ppb_pkg::HISTORY_LENGTH_DEF,
  parameter int INDEX_BITS     = ppb_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode,
  input  logic [63:0]                       branch_address,
  input  logic [31:0]                       history,
  input  logic                              outcome_taken,
  input  logic signed [ppb_pkg::DOT_W-1:0]  fetch_sum,
  input  logic                              prediction_made,
  input  logic                              prediction_direction,
  // result channel
  output logic                              done,
  output logic [ppb_pkg::ROW_W-1:0]         row_index,
  output logic signed [ppb_pkg::DOT_W-1:0]  dot_sum,
  output logic                              confident,
  output logic                              predict_taken,
  output logic                              weights_updated,
  // config port
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [ppb_pkg::CFG_W-1:0]         cfg_data
);

  localparam int LANES  = HISTORY_LENGTH + 1;     // bias + one per history bit
  localparam int ROWS   = 1 << INDEX_BITS;
  // exact sum range: +/- LANES * 128
  localparam int SUM_W  = $clog2(LANES * 128 + 1) + 1;
  localparam int CMP_W  = ((SUM_W > ppb_pkg::DOT_W) ? SUM_W : ppb_pkg::DOT_W) + 1;
  localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'(ppb_pkg::DOT_MAX);
  localparam logic signed [CMP_W-1:0] SAT_LO = -SAT_HI - CMP_W'(1);

  ppb_pkg::st_t       state, state_next;
  ppb_pkg::lane_ctrl_t lane_ctrl;
  logic               merge_load;
  logic               accept;

  logic [ppb_pkg::THR_W-1:0] thr;
  logic [ppb_pkg::LIM_W-1:0] lim;
  logic [INDEX_BITS-1:0]     clr_cnt;

  // captured item
  logic                      mode_q;
  logic [HISTORY_LENGTH-1:0] hist_q;
  logic [INDEX_BITS-1:0]     row_q;
  logic                      taken_q;
  logic                      upd_q;

  // row index: (addr >> 1) ^ history folded to INDEX_BITS
  logic [31:0]               hist_sh;
  logic [INDEX_BITS-1:0]     row_in;
  logic [INDEX_BITS+ppb_pkg::ROW_W-1:0] row_ext;

  // training decision, made at accept from fetch-time data
  logic signed [ppb_pkg::DOT_W:0] thr_f;
  logic signed [ppb_pkg::DOT_W:0] fs_x;
  logic                           upd_in;

  logic [LANES-1:0]                      lane_hbit;
  logic [LANES-1:0][ppb_pkg::TERM_W-1:0] lane_term;
  logic [LANES-1:0]                      lane_chg;
  logic [INDEX_BITS-1:0]                 wr_addr;

  logic signed [SUM_W-1:0] total;
  logic signed [CMP_W-1:0] sum_x;
  logic signed [CMP_W-1:0] thr_x;
  logic signed [CMP_W-1:0] sat_x;
  logic                    conf_v;

  assign hist_sh = history >> INDEX_BITS;
  assign row_in  = branch_address[INDEX_BITS:1] ^ history[INDEX_BITS-1:0]
                 ^ hist_sh[INDEX_BITS-1:0];

  assign thr_f  = (ppb_pkg::DOT_W+1)'(thr);
  assign fs_x   = (ppb_pkg::DOT_W+1)'(fetch_sum);
  assign upd_in = (prediction_made && (prediction_direction != outcome_taken))
               || ((fs_x >= -thr_f) && (fs_x <= thr_f));

  assign busy   = (state != ppb_pkg::ST_IDLE);
  assign accept = start && !busy;

  // config registers; writes are taken in any state
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ppb_pkg::THR_RESET;
      lim <= ppb_pkg::LIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppb_pkg::CFG_THRESHOLD: thr <= cfg_data[ppb_pkg::THR_W-1:0];
        ppb_pkg::CFG_LIMIT:     lim <= cfg_data[ppb_pkg::LIM_W-1:0];
      endcase
    end
  end

  // state register and clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ppb_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ppb_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + INDEX_BITS'(1);
      end
    end
  end

  // next state and per-stage controls
  always_comb begin
    state_next        = state;
    lane_ctrl.capture = 1'b0;
    lane_ctrl.wr_en   = 1'b0;
    lane_ctrl.clear   = 1'b0;
    merge_load        = 1'b0;
    unique case (state)
      ppb_pkg::ST_CLEAR: begin
        lane_ctrl.wr_en = 1'b1;
        lane_ctrl.clear = 1'b1;
        if (&clr_cnt) begin
          state_next = ppb_pkg::ST_IDLE;
        end
      end
      ppb_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ppb_pkg::ST_READ;
        end
      end
      ppb_pkg::ST_READ: begin
        lane_ctrl.capture = 1'b1;
        state_next        = ppb_pkg::ST_LANE;
      end
      ppb_pkg::ST_LANE: begin
        // write back only for a train item that needs it
        lane_ctrl.wr_en = mode_q && upd_q;
        merge_load      = 1'b1;
        state_next      = ppb_pkg::ST_SUM;
      end
      ppb_pkg::ST_SUM: begin
        state_next = ppb_pkg::ST_IDLE;
      end
      default: begin
        state_next = ppb_pkg::ST_IDLE;
      end
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      hist_q  <= history[HISTORY_LENGTH-1:0];
      row_q   <= row_in;
      taken_q <= outcome_taken;
      upd_q   <= upd_in;
    end
  end

  assign wr_addr = (state == ppb_pkg::ST_CLEAR) ? clr_cnt : row_q;

  // lane 0 is the bias weight, driven by a constant +1
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    if (l == 0) begin : g_bias
      assign lane_hbit[l] = 1'b1;
    end else begin : g_hist
      assign lane_hbit[l] = hist_q[l-1];
    end

    ppb_lane #(
      .DEPTH(ROWS)
    ) u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .rd_en   (accept),
      .rd_addr (row_in),
      .wr_addr (wr_addr),
      .hist_bit(lane_hbit[l]),
      .taken   (taken_q),
      .limit   (lim),
      .term    (lane_term[l]),
      .changed (lane_chg[l])
    );
  end

  ppb_merge #(
    .LANES(LANES),
    .SUM_W(SUM_W)
  ) u_merge (
    .clk  (clk),
    .load (merge_load),
    .terms(lane_term),
    .total(total)
  );

  // final compare against the exact sum, then saturate to the field
  always_comb begin
    sum_x  = CMP_W'(total);
    thr_x  = CMP_W'(thr);
    conf_v = (sum_x > thr_x) || (sum_x < -thr_x);
    if (sum_x > SAT_HI) begin
      sat_x = SAT_HI;
    end else if (sum_x < SAT_LO) begin
      sat_x = SAT_LO;
    end else begin
      sat_x = sum_x;
    end
  end

  assign row_ext = (INDEX_BITS+ppb_pkg::ROW_W)'(row_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ppb_pkg::ST_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ppb_pkg::ST_SUM) begin
      row_index <= row_ext[ppb_pkg::ROW_W-1:0];
      if (mode_q) begin
        dot_sum         <= '0;
        confident       <= 1'b0;
        predict_taken   <= 1'b0;
        weights_updated <= upd_q && (|lane_chg);
      end else begin
        dot_sum         <= sat_x[ppb_pkg::DOT_W-1:0];
        confident       <= conf_v;
        predict_taken   <= conf_v && (sum_x > CMP_W'(0));
        weights_updated <= 1'b0;
      end
    end
  end

  // a result follows only the final sum stage
  a_done_after_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ppb_pkg::ST_SUM))
    else $error("done without a sum stage");

  // table writes only during the clearing sweep or lane write-back
  a_write_stage: assert property (@(posedge clk) disable iff (rst)
    lane_ctrl.wr_en |-> (state == ppb_pkg::ST_CLEAR || (state == ppb_pkg::ST_LANE && mode_q)))
    else $error("weight write outside its stage");

  // no item taken while the table is being cleared
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ppb_pkg::ST_CLEAR) |-> busy)
    else $error("not busy during clear");

  // an update report carries no prediction
  a_update_no_pred: assert property (@(posedge clk) disable iff (rst)
    (done && weights_updated) |-> (!confident && !predict_taken && dot_sum == '0))
    else $error("train result carries prediction fields");

endmodule

>>> dv/tb_perceptron_branch_predictor_unit.sv
// Self-checking testbench for perceptron_branch_predictor_unit.
// Holds its own copy of the weight table and registers to predict every result.
// Depends on ppb_pkg and the RTL under src only.
module tb_perceptron_branch_predictor_unit;

  localparam int HL = ppb_pkg::HISTORY_LENGTH_DEF;
  localparam int IB = ppb_pkg::INDEX_BITS_DEF;
  localparam int NUM_ROWS = 1 << IB;
  localparam int RESULT_LATENCY = 3;   // accept edge to done
  localparam int POOL_SIZE = 16;
  localparam int EXP_DEPTH = 8;

  localparam bit MODE_PREDICT = 1'b0;
  localparam bit MODE_TRAIN   = 1'b1;

  typedef struct {
    logic [ppb_pkg::ROW_W-1:0]        row;
    logic signed [ppb_pkg::DOT_W-1:0] dot;
    logic                             confident;
    logic                             taken;
    logic                             updated;
  } row_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic mode;
  logic [63:0] branch_address;
  logic [31:0] history;
  logic outcome_taken;
  logic signed [ppb_pkg::DOT_W-1:0] fetch_sum;
  logic prediction_made;
  logic prediction_direction;
  logic done;
  logic [ppb_pkg::ROW_W-1:0] row_index;
  logic signed [ppb_pkg::DOT_W-1:0] dot_sum;
  logic confident;
  logic predict_taken;
  logic weights_updated;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [ppb_pkg::CFG_W-1:0] cfg_data;

  // Shadow of the block: weight rows (bias first) and the two registers.
  logic signed [ppb_pkg::WEIGHT_W-1:0] shadow_weights [0:NUM_ROWS-1][0:HL];
  int shadow_thr;
  int shadow_lim;

  // Expected results in order; the sender advances exp_wr, the checker exp_rd.
  row_result_t exp_q [0:EXP_DEPTH-1];
  int exp_wr = 0;
  int exp_rd = 0;
  row_result_t last_expected;   // expectation of the item most recently accepted
  int fail_count = 0;

  // Branch pool for well-formed predict/train sequences.
  logic [63:0] pool_addr [0:POOL_SIZE-1];
  logic [31:0] pool_hist [0:POOL_SIZE-1];
  bit          pool_bias [0:POOL_SIZE-1];

  perceptron_branch_predictor_unit dut (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .mode                 (mode),
    .branch_address       (branch_address),
    .history              (history),
    .outcome_taken        (outcome_taken),
    .fetch_sum            (fetch_sum),
    .prediction_made      (prediction_made),
    .prediction_direction (prediction_direction),
    .done                 (done),
    .row_index            (row_index),
    .dot_sum              (dot_sum),
    .confident            (confident),
    .predict_taken        (predict_taken),
    .weights_updated      (weights_updated),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lookup or train one row of the shadow table; returns what the block must report.
  function automatic row_result_t score_or_train_row(bit m, logic [63:0] a, logic [31:0] h,
                                                     bit oc,
                                                     logic signed [ppb_pkg::DOT_W-1:0] fs,
                                                     bit pm, bit pd);
    row_result_t r;
    logic [IB-1:0] ri;
    int sum, wt, nv, y, t, stp, i;
    bit wrong, low;
    // row = (addr >> 1) ^ folded history, kept to the index width
    ri = IB'((a >> 1) ^ 64'(h ^ (h >> IB)));
    r.row = ppb_pkg::ROW_W'(ri);
    r.dot = '0;
    r.confident = 1'b0;
    r.taken = 1'b0;
    r.updated = 1'b0;
    if (m == MODE_PREDICT) begin
      sum = shadow_weights[ri][0];
      for (i = 0; i < HL; i++) begin
        wt = shadow_weights[ri][i+1];
        sum += h[i] ? wt : -wt;
      end
      // confidence uses the exact sum; only the reported field saturates
      r.confident = (sum > shadow_thr) || (sum < -shadow_thr);
      r.taken = r.confident && (sum > 0);
      if (sum > ppb_pkg::DOT_MAX) sum = ppb_pkg::DOT_MAX;
      if (sum < -ppb_pkg::DOT_MAX - 1) sum = -ppb_pkg::DOT_MAX - 1;
      r.dot = ppb_pkg::DOT_W'(sum);
    end else begin
      y = fs;
      wrong = pm && (pd != oc);
      low = (y >= -shadow_thr) && (y <= shadow_thr);
      if (wrong || low) begin
        t = oc ? 1 : -1;
        for (i = 0; i <= HL; i++) begin
          wt = shadow_weights[ri][i];
          stp = (i == 0 || h[i-1]) ? t : -t;
          nv = wt + stp;
          if (nv > shadow_lim) nv = shadow_lim;
          if (nv < -shadow_lim) nv = -shadow_lim;
          if (nv != wt) r.updated = 1'b1;
          shadow_weights[ri][i] = nv[ppb_pkg::WEIGHT_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // Present one item and hold it until the block takes it; start stays high afterwards.
  task automatic send_item(input bit m, input logic [63:0] a, input logic [31:0] h,
                           input bit oc, input logic signed [ppb_pkg::DOT_W-1:0] fs,
                           input bit pm, input bit pd);
    start <= 1'b1;
    mode <= m;
    branch_address <= a;
    history <= h;
    outcome_taken <= oc;
    fetch_sum <= fs;
    prediction_made <= pm;
    prediction_direction <= pd;
    @(posedge clk);
    while (busy) @(posedge clk);
    last_expected = score_or_train_row(m, a, h, oc, fs, pm, pd);
    exp_q[exp_wr % EXP_DEPTH] = last_expected;
    exp_wr++;
  endtask

  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender pause until every result is back and the block has gone idle.
  task automatic settle_block();
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Both registers, one per cycle; the shadow copies take the masked values.
  task automatic write_regs(input logic [ppb_pkg::CFG_W-1:0] thr_data,
                            input logic [ppb_pkg::CFG_W-1:0] lim_data);
    cfg_we <= 1'b1;
    cfg_index <= ppb_pkg::CFG_THRESHOLD;
    cfg_data <= thr_data;
    @(posedge clk);
    cfg_index <= ppb_pkg::CFG_LIMIT;
    cfg_data <= lim_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_thr = thr_data[ppb_pkg::THR_W-1:0];
    shadow_lim = lim_data[ppb_pkg::LIM_W-1:0];
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Results cannot be held off: every done cycle is matched against the oldest item.
  always @(posedge clk) begin : check_results
    row_result_t want;
    if (!rst && done === 1'b1) begin
      if (exp_wr == exp_rd) begin
        $error("result with no item outstanding: row_index %0d", row_index);
        fail_count++;
      end else begin
        want = exp_q[exp_rd % EXP_DEPTH];
        exp_rd++;
        check_field("row_index", want.row, row_index);
        check_field("dot_sum", want.dot, dot_sum);
        check_field("confident", want.confident, confident);
        check_field("predict_taken", want.taken, predict_taken);
        check_field("weights_updated", want.updated, weights_updated);
      end
    end
  end

  // Fresh table: all weights zero, so every lookup sums to zero.
  task automatic test_cold_lookup();
    send_item(MODE_PREDICT, 64'h0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
    send_item(MODE_PREDICT, '1, '1, 1'b1, '1, 1'b1, 1'b1);
  endtask

  // Training rule at reset settings: low-confidence and wrong cases update, others don't.
  task automatic test_training_rules();
    logic [63:0] a;
    logic [31:0] h;
    a = 64'h0000_0000_0000_0010;
    h = 32'h0000_A5C3;
    send_item(MODE_TRAIN, a, h, 1'b1, 0, 1'b0, 1'b0);        // unconfident
    send_item(MODE_TRAIN, a, h, 1'b1, 45, 1'b1, 1'b1);       // sum on the threshold
    send_item(MODE_TRAIN, a, h, 1'b1, 46, 1'b1, 1'b1);       // confident and right
    send_item(MODE_TRAIN, a, h, 1'b1, -46, 1'b1, 1'b0);      // confident and wrong
    send_item(MODE_TRAIN, a, h, 1'b0, 2159, 1'b0, 1'b1);     // no prediction issued
    send_item(MODE_TRAIN, a, h, 1'b0, -2159, 1'b1, 1'b1);    // wrong, far negative
    send_item(MODE_TRAIN, a, h, 1'b0, -45, 1'b0, 1'b0);      // lower threshold edge
    send_item(MODE_TRAIN, a, h, 1'b0, 4095, 1'b0, 1'b0);     // field extremes
    send_item(MODE_TRAIN, a, h, 1'b1, -4096, 1'b0, 1'b1);
    send_item(MODE_PREDICT, a, h, 1'b0, 0, 1'b0, 1'b0);
  endtask

  // Saturation, a limit lowered below stored weights, and a limit of zero.
  task automatic test_weight_clamp();
    logic [63:0] a;
    logic [31:0] h;
    a = 64'hFFFF_FFFF_FFFF_FFFE;
    h = 32'hFFFF_0000;
    settle_block();
    write_regs(12'd0, 12'd2);
    repeat (3) send_item(MODE_TRAIN, a, h, 1'b1, 0, 1'b0, 1'b0);  // third one saturates
    send_item(MODE_PREDICT, a, h, 1'b0, 0, 1'b0, 1'b0);
    settle_block();
    write_regs(12'd0, 12'h081);       // upper data bits dropped: limit 1
    send_item(MODE_PREDICT, a, h, 1'b0, 0, 1'b0, 1'b0);   // stored weights still 2
    send_item(MODE_TRAIN, a, h, 1'b1, 0, 1'b0, 1'b0);
    settle_block();
    write_regs(12'd0, 12'h080);       // limit 0
    send_item(MODE_TRAIN, a, h, 1'b1, 0, 1'b0, 1'b0);
    send_item(MODE_PREDICT, a, h, 1'b0, 0, 1'b0, 1'b0);
  endtask

  // Largest threshold: nothing is confident and every train updates.
  task automatic test_threshold_extremes();
    settle_block();
    write_regs(12'hFFF, 12'd127);
    send_item(MODE_PREDICT, 64'h0000_0000_0000_0010, 32'h0000_A5C3, 1'b0, 0, 1'b0, 1'b0);
    send_item(MODE_TRAIN, 64'h0000_0000_0000_0010, 32'h0000_A5C3, 1'b1, 2159, 1'b1, 1'b1);
  endtask

  // Mostly predict-then-train pairs on a small branch pool, with random noise items.
  task automatic run_random_phase(input int items, input bit allow_idle);
    int n, b;
    logic [31:0] h;
    bit oc, idle_now;
    idle_now = 1'b1;
    n = 0;
    while (n < items) begin
      if ($urandom_range(0, 31) == 0) idle_now = !idle_now;   // stretches without gaps
      if (allow_idle && idle_now && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 8));
      if ($urandom_range(0, 4) == 0) begin
        send_item($urandom_range(0, 1), {$urandom, $urandom}, $urandom,
                  $urandom_range(0, 1), ppb_pkg::DOT_W'($urandom), $urandom_range(0, 1),
                  $urandom_range(0, 1));
        n++;
      end else begin
        b = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 3) == 0) pool_hist[b] = $urandom;
        h = pool_hist[b];
        oc = ($urandom_range(0, 99) < 85) ? pool_bias[b] : !pool_bias[b];
        send_item(MODE_PREDICT, pool_addr[b], h, 1'b0, 0, 1'b0, 1'b0);
        if (allow_idle && idle_now && $urandom_range(0, 3) == 0)
          idle_sender($urandom_range(1, 8));
        // train with what the fetch-time lookup returned
        send_item(MODE_TRAIN, pool_addr[b], h, oc, last_expected.dot,
                  last_expected.confident, last_expected.taken);
        n += 2;
      end
    end
  endtask

  task automatic test_random_traffic();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_addr[i] = {$urandom, $urandom};
      pool_hist[i] = $urandom;
      pool_bias[i] = $urandom_range(0, 1);
    end
    settle_block();
    write_regs(12'd45, 12'd127);
    run_random_phase(300, 1'b1);
    settle_block();
    write_regs(12'd0, 12'd1);
    run_random_phase(150, 1'b1);
    settle_block();
    write_regs(ppb_pkg::CFG_W'($urandom_range(1, 200)), ppb_pkg::CFG_W'($urandom_range(2, 30)));
    run_random_phase(200, 1'b1);
    settle_block();
    write_regs(12'hFFF, 12'd127);
    run_random_phase(80, 1'b1);
    settle_block();
    write_regs(12'd20, 12'd64);
    run_random_phase(200, 1'b0);   // closing stretch at full rate
  endtask

  initial begin : main_sequence
    int r, k;
    for (r = 0; r < NUM_ROWS; r++)
      for (k = 0; k <= HL; k++) shadow_weights[r][k] = '0;
    shadow_thr = ppb_pkg::THR_RESET;
    shadow_lim = ppb_pkg::LIM_RESET;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_PREDICT;
    branch_address <= '0;
    history <= '0;
    outcome_taken <= 1'b0;
    fetch_sum <= '0;
    prediction_made <= 1'b0;
    prediction_direction <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= ppb_pkg::CFG_THRESHOLD;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // the table sweep after reset shows up as busy; send_item waits it out
    test_cold_lookup();
    test_training_rules();
    test_weight_clamp();
    test_threshold_extremes();
    test_random_traffic();

    start <= 1'b0;
    for (k = 0; k < 200 && exp_wr != exp_rd; k++) @(posedge clk);
    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (exp_wr != exp_rd) begin
      $error("%0d expected results never arrived", exp_wr - exp_rd);
      fail_count += exp_wr - exp_rd;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
